[src/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the blob principal-axis angle block
// Coordinate widths, accumulator widths, the CORDIC arctangent table and the
// state encodings used by the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;

  localparam int CoordBits  = 10;
  localparam int MaxPoints  = 65536;
  localparam int CountW     = 17;
  localparam int SumW       = 27;
  localparam int SqW        = 37;
  localparam int WideW      = 64;
  localparam int ZW         = 24;
  localparam int AngleW     = 14;
  localparam int CordicSteps = 16;
  localparam int StepW      = 4;
  localparam int QueueDepth = 2;

  localparam logic [ZW-1:0] QuarterTurn = ZW'(90 * 8192);
  localparam logic [ZW-1:0] HalfTurn    = ZW'(180 * 8192);
  localparam logic [ZW-1:0] FullTurn    = ZW'(360 * 8192);
  localparam logic [AngleW-1:0] AngleWrap = AngleW'(11520);

  // Accumulated moments of one finished blob.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SumW-1:0]   sr;
    logic [SumW-1:0]   sc;
    logic [SqW-1:0]    srr;
    logic [SqW-1:0]    scc;
    logic [SqW-1:0]    src;
    logic              ovf;
  } moments_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_DIFF, S_NORM, S_CORDIC, S_PLACE, S_OUT
  } back_state_e;

  // atan(2^-i) in 1/8192 degree.
  function automatic logic [ZW-1:0] atan_entry(input logic [StepW-1:0] i);
    logic [ZW-1:0] v;
    unique case (i)
      4'd0:  v = ZW'(368640);
      4'd1:  v = ZW'(217621);
      4'd2:  v = ZW'(114985);
      4'd3:  v = ZW'(58368);
      4'd4:  v = ZW'(29297);
      4'd5:  v = ZW'(14663);
      4'd6:  v = ZW'(7333);
      4'd7:  v = ZW'(3667);
      4'd8:  v = ZW'(1833);
      4'd9:  v = ZW'(917);
      4'd10: v = ZW'(458);
      4'd11: v = ZW'(229);
      4'd12: v = ZW'(115);
      4'd13: v = ZW'(57);
      4'd14: v = ZW'(29);
      default: v = ZW'(14);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/bpa_front.sv]
// ----------------------------------------------------------------------------
// bpa_front: moment accumulator
// Takes one point per cycle while the queue is not full, updates count and sums,
// and on the last point pushes the finished moments into the queue and clears for the next blob.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [9:0]                    point_row_i,
  input  wire logic [9:0]                    point_col_i,
  input  wire logic                          last_point_i,
  output logic                               push_o,
  output bpa_pkg::moments_t                  push_data_o,
  input  wire logic                          full_i
);
  import bpa_pkg::*;

  moments_t acc_q, acc_d;
  logic [CoordBits-1:0] r, c;
  logic fire, room;

  assign r = point_row_i[CoordBits-1:0];
  assign c = point_col_i[CoordBits-1:0];
  assign in_ready = !full_i;
  assign fire = in_valid && in_ready;
  assign room = acc_q.count < CountW'(MaxPoints);

  // Next moments including the current point.
  always_comb begin
    acc_d = acc_q;
    if (room) begin
      acc_d.count = acc_q.count + 1'b1;
      acc_d.sr  = acc_q.sr + SumW'(r);
      acc_d.sc  = acc_q.sc + SumW'(c);
      acc_d.srr = acc_q.srr + SqW'(r * r);
      acc_d.scc = acc_q.scc + SqW'(c * c);
      acc_d.src = acc_q.src + SqW'(r * c);
    end else begin
      acc_d.ovf = 1'b1;
    end
  end

  assign push_o = fire && last_point_i;
  assign push_data_o = acc_d;

  // Accumulators clear after each finished blob.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (fire) begin
      acc_q <= last_point_i ? '0 : acc_d;
    end
  end

endmodule
`default_nettype wire

[src/bpa_queue.sv]
// ----------------------------------------------------------------------------
// bpa_queue: short FIFO of finished blob moments
// Decouples the accumulator from the angle engine.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bpa_pkg::moments_t push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output bpa_pkg::moments_t      pop_data_o
);
  import bpa_pkg::*;

  moments_t mem_q [QueueDepth];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'(QueueDepth);
  assign empty_o = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

[src/bpa_back.sv]
// ----------------------------------------------------------------------------
// bpa_back: covariance and angle engine
// Forms the scaled covariance terms with one multiplier pass per term,
// normalises, runs a 16-step CORDIC and places the angle in its quadrant; a degenerate blob skips both.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 empty_i,
  input  wire bpa_pkg::moments_t    data_i,
  output logic                      pop_o,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [13:0]               angle_o,
  output logic [16:0]               point_count_o,
  output logic                      degenerate_o,
  output logic                      overflow_o
);
  import bpa_pkg::*;

  back_state_e state_q, state_d;
  moments_t m_q;
  logic [WideW-1:0] a_q, c_q, b_q;
  logic signed [WideW-1:0] x_q, y_q;
  logic [WideW-1:0] mx_q, my_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [ZW:0] z_q;
  logic [StepW-1:0] i_q;
  logic [AngleW-1:0] ang_q;
  logic degen_q;

  logic [WideW-1:0] prod_n, prod_s, diff;
  logic [SqW-1:0] mul_a;
  logic [SumW-1:0] mul_b, mul_c;
  logic signed [33:0] dx, dy;
  logic signed [ZW:0] zc;
  logic signed [ZW+1:0] phi;
  logic [ZW+1:0] phr;
  logic [AngleW+2:0] ang_w;

  // One covariance term per cycle: n*S2 - S1a*S1b.
  always_comb begin
    unique case (state_q)
      S_MUL1:  begin mul_a = m_q.srr; mul_b = m_q.sr; mul_c = m_q.sr; end
      S_MUL2:  begin mul_a = m_q.scc; mul_b = m_q.sc; mul_c = m_q.sc; end
      default: begin mul_a = m_q.src; mul_b = m_q.sr; mul_c = m_q.sc; end
    endcase
    prod_n = WideW'(m_q.count) * WideW'(mul_a);
    prod_s = WideW'(mul_b) * WideW'(mul_c);
    diff = prod_n - prod_s;
  end

  // CORDIC step with shifts that truncate toward zero, plus quadrant placement and rounding of the angle.
  always_comb begin
    dx = (cy_q >= 0) ? (cy_q >>> i_q) : -((-cy_q) >>> i_q);
    dy = (cx_q >= 0) ? (cx_q >>> i_q) : -((-cx_q) >>> i_q);
    zc = (z_q < 0) ? '0 : (z_q > $signed({1'b0, QuarterTurn}) ?
         $signed({1'b0, QuarterTurn}) : z_q);
    if (x_q >= 0 && y_q >= 0)  phi = (ZW+2)'(zc);
    else if (x_q < 0 && y_q >= 0) phi = $signed({2'b0, HalfTurn}) - zc;
    else if (x_q < 0) phi = $signed({2'b0, HalfTurn}) + zc;
    else phi = $signed({2'b0, FullTurn}) - zc;
    if (phi >= $signed({2'b0, FullTurn})) phi = phi - $signed({2'b0, FullTurn});
    phr = phi;
    ang_w = (AngleW+3)'((phr + (ZW+2)'(128)) >> 8);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    pop_o = 1'b0;
    unique case (state_q)
      S_IDLE:   if (!empty_i) begin pop_o = 1'b1; state_d = S_MUL1; end
      S_MUL1:   state_d = S_MUL2;
      S_MUL2:   state_d = S_MUL3;
      S_MUL3:   state_d = S_DIFF;
      S_DIFF:   state_d = S_NORM;
      S_NORM:   if (degen_q) state_d = S_OUT;
                else if ((mx_q >> 30) == '0 && (my_q >> 30) == '0) state_d = S_CORDIC;
      S_CORDIC: if (i_q == StepW'(CordicSteps - 1)) state_d = S_PLACE;
      S_PLACE:  state_d = S_OUT;
      S_OUT:    if (out_ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        m_q <= data_i;
        i_q <= '0;
        z_q <= '0;
        ang_q <= '0;
      end
      S_MUL1: a_q <= diff;
      S_MUL2: c_q <= diff;
      S_MUL3: b_q <= diff;
      S_DIFF: begin
        x_q <= $signed(a_q - c_q);
        y_q <= $signed(b_q + b_q);
        degen_q <= (a_q == c_q) && ((b_q + b_q) == '0);
      end
      S_NORM: begin
        if (state_d == S_NORM) begin
          mx_q <= mx_q >> 1;
          my_q <= my_q >> 1;
        end else begin
          cx_q <= $signed({4'b0, mx_q[29:0]});
          cy_q <= $signed({4'b0, my_q[29:0]});
        end
      end
      S_CORDIC: begin
        if (cy_q >= 0) begin
          cx_q <= cx_q + dx; cy_q <= cy_q - dy;
          z_q <= z_q + $signed({1'b0, atan_entry(i_q)});
        end else begin
          cx_q <= cx_q - dx; cy_q <= cy_q + dy;
          z_q <= z_q - $signed({1'b0, atan_entry(i_q)});
        end
        i_q <= i_q + 1'b1;
      end
      S_PLACE: ang_q <= (ang_w >= (AngleW+3)'(AngleWrap)) ? '0 : AngleW'(ang_w);
      default: ;
    endcase
    // Magnitudes of the signed differences are loaded on entry to normalisation.
    if (state_q == S_DIFF) begin
      mx_q <= (a_q - c_q) >> 63 != 0 ? -(a_q - c_q) : (a_q - c_q);
      my_q <= (b_q + b_q) >> 63 != 0 ? -(b_q + b_q) : (b_q + b_q);
    end
  end

  assign out_valid = state_q == S_OUT;
  assign angle_o = ang_q;
  assign point_count_o = m_q.count;
  assign degenerate_o = degen_q;
  assign overflow_o = m_q.ovf;

endmodule
`default_nettype wire

[src/blob_principal_axis_angle.sv]
// ----------------------------------------------------------------------------
// blob_principal_axis_angle: principal-axis orientation of a pixel blob
// Accumulates second moments of a stream of points and reports the angle.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_ready) carries one pixel per transfer, with
//  last_point_i marking the final pixel of a blob. The accumulator takes one
//  point per cycle; in_ready drops only when the two-entry queue of finished
//  blobs is full.
//  Output channel (out_valid/out_ready) carries one result per blob: angle in
//  1/32 degree, point count, degenerate and overflow flags.
//  After the last point a blob goes through the queue; the shared multiplier
//  datapath forms its covariance terms in turn, normalisation scales the
//  differences and the iterative CORDIC unit runs 16 iterations before the
//  quadrant placement. A degenerate blob skips the CORDIC and goes from
//  normalisation to the output. Throughput is one point per cycle within a
//  blob while the queue has room; the engine handles one blob at a time and
//  takes the next only once the result is taken, so a run of short blobs
//  fills the queue and stalls the input. Reset clears the accumulators, the
//  queue and the engine. A stalled result is held; further blobs queue.
`default_nettype none
module blob_principal_axis_angle (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [9:0]  point_row_i,
  input  wire logic [9:0]  point_col_i,
  input  wire logic        last_point_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      angle_o,
  output logic [16:0]      point_count_o,
  output logic             degenerate_o,
  output logic             overflow_o
);
  import bpa_pkg::*;

  logic push, full, pop, empty;
  moments_t push_data, pop_data;

  // Front: accumulate moments.
  bpa_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .point_row_i, .point_col_i,
    .last_point_i, .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  // Queue of finished blobs.
  bpa_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  // Back: angle engine.
  bpa_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .data_i(pop_data), .pop_o(pop),
    .out_valid, .out_ready, .angle_o, .point_count_o, .degenerate_o, .overflow_o
  );

endmodule
`default_nettype wire

[tb/sv/blob_principal_axis_angle_test.sv]
// ----------------------------------------------------------------------------
// blob_principal_axis_angle_test: self-checking bench for the blob angle block
// Streams blobs of pixel coordinates through the block, predicts each blob's
// principal-axis angle, count and flags, and compares every result transfer.
// ----------------------------------------------------------------------------
module blob_principal_axis_angle_test;
  import bpa_pkg::*;

  typedef struct {
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } pixel_t;

  typedef struct {
    logic [13:0] angle;
    logic [16:0] count;
    logic        degen;
    logic        ovf;
  } blob_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [9:0]  point_row_i;
  logic [9:0]  point_col_i;
  logic        last_point_i;
  logic        out_valid;
  logic        out_ready;
  logic [13:0] angle_o;
  logic [16:0] point_count_o;
  logic        degenerate_o;
  logic        overflow_o;

  pixel_t       pixel_q[$];
  blob_result_t result_q[$];
  int           mismatches;
  int           results_seen;
  int           pixels_sent;
  int           hold_cycles;
  bit           calm;
  bit           pause_req;
  bit           hold_req;
  bit           hold_done;

  // Predictor state, mirrors the accumulators of the block.
  longint unsigned acc_n, acc_r, acc_c, acc_rr, acc_cc, acc_rc;
  bit              acc_ovf;

  blob_principal_axis_angle i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .point_row_i   (point_row_i),
    .point_col_i   (point_col_i),
    .last_point_i  (last_point_i),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .angle_o       (angle_o),
    .point_count_o (point_count_o),
    .degenerate_o  (degenerate_o),
    .overflow_o    (overflow_o)
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic longint shr_to_zero(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  // First-quadrant CORDIC angle in 1/8192 degree.
  function automatic longint first_quadrant(longint unsigned ax, longint unsigned ay);
    longint unsigned m;
    longint cx, cy, z, dx, dy;
    int s;
    longint tab[16] = '{368640, 217621, 114985, 58368, 29297, 14663, 7333, 3667,
                        1833, 917, 458, 229, 115, 57, 29, 14};
    m = (ax > ay) ? ax : ay;
    s = 0;
    z = 0;
    while (s < 63 && (m >> s) >= (64'd1 << 30)) s++;
    cx = longint'(ax >> s);
    cy = longint'(ay >> s);
    for (int i = 0; i < 16; i++) begin
      dx = shr_to_zero(cy, i);
      dy = shr_to_zero(cx, i);
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += tab[i];
      end else begin
        cx -= dx; cy += dy; z -= tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 8192) z = 90 * 8192;
    return z;
  endfunction

  // Accumulates one pixel; returns 1 with the blob's result on the last one.
  function automatic bit accumulate_pixel(pixel_t p, output blob_result_t res);
    longint unsigned a, cc, b;
    longint x, y, alpha, phi;
    longint unsigned ang, mx, my;
    if (acc_n >= MaxPoints) begin
      acc_ovf = 1'b1;
    end else begin
      acc_n++;
      acc_r  += p.row;
      acc_c  += p.col;
      acc_rr += longint'(p.row) * p.row;
      acc_cc += longint'(p.col) * p.col;
      acc_rc += longint'(p.row) * p.col;
    end
    if (!p.last) return 1'b0;
    a  = acc_n * acc_rr - acc_r * acc_r;
    cc = acc_n * acc_cc - acc_c * acc_c;
    b  = acc_n * acc_rc - acc_r * acc_c;
    x = longint'(a - cc);
    y = longint'(b + b);
    ang = 0;
    res.degen = (x == 0 && y == 0);
    if (!res.degen) begin
      mx = (x < 0) ? longint'(-x) : x;
      my = (y < 0) ? longint'(-y) : y;
      alpha = first_quadrant(mx, my);
      if (x >= 0 && y >= 0) phi = alpha;
      else if (x < 0 && y >= 0) phi = 180 * 8192 - alpha;
      else if (x < 0) phi = 180 * 8192 + alpha;
      else phi = 360 * 8192 - alpha;
      if (phi >= 360 * 8192) phi -= 360 * 8192;
      if (phi < 0) phi += 360 * 8192;
      ang = (phi + 128) >> 8;
      if (ang >= 11520) ang = 0;
    end
    res.angle = ang[13:0];
    res.count = acc_n[16:0];
    res.ovf   = acc_ovf;
    {acc_n, acc_r, acc_c, acc_rr, acc_cc, acc_rc} = '0;
    acc_ovf = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch in result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic add_pixel(int r, int c, bit last);
    pixel_t p;
    p.row = r[9:0];
    p.col = c[9:0];
    p.last = last;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  // A random blob: mostly elongated segments with jitter, sometimes scatter.
  task automatic add_blob(int len);
    int r0, c0, dr, dc;
    r0 = $urandom_range(0, 1023);
    c0 = $urandom_range(0, 1023);
    dr = $urandom_range(0, 6) - 3;
    dc = $urandom_range(0, 6) - 3;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 4) == 0)
        add_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), k == len - 1);
      else
        add_pixel(r0 + dr * k + $urandom_range(0, 2), c0 + dc * k + $urandom_range(0, 2),
                  k == len - 1);
    end
  endtask

  // Driver: presents queued pixels, holds each until its transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid     <= 1'b0;
      point_row_i  <= '0;
      point_col_i  <= '0;
      last_point_i <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() > 0 && !pause_req && (calm || $urandom_range(0, 99) >= 31)) begin
        in_valid     <= 1'b1;
        point_row_i  <= pixel_q[0].row;
        point_col_i  <= pixel_q[0].col;
        last_point_i <= pixel_q[0].last;
        pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input monitor: predicts the result of each accepted pixel.
  always @(posedge clk_i) begin
    pixel_t p;
    blob_result_t res;
    if (rst_ni && in_valid && in_ready) begin
      p.row = point_row_i;
      p.col = point_col_i;
      p.last = last_point_i;
      pixels_sent++;
      if (accumulate_pixel(p, res)) result_q.insert(result_q.size(), res);
    end
  end

  // Receiver readiness, including a long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready   <= 1'b0;
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cycles <= 300;
      hold_done   <= 1'b1;
      out_ready   <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  // Output monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    blob_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        report_mismatch("unexpected transfer, angle", angle_o, 0);
      end else begin
        want = result_q.pop_front();
        if (angle_o !== want.angle) report_mismatch("angle", angle_o, want.angle);
        if (point_count_o !== want.count) report_mismatch("count", point_count_o, want.count);
        if (degenerate_o !== want.degen) report_mismatch("degenerate", degenerate_o, want.degen);
        if (overflow_o !== want.ovf) report_mismatch("overflow", overflow_o, want.ovf);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    mismatches = 0;
    results_seen = 0;
    pixels_sent = 0;
    calm = 1'b0;
    pause_req = 1'b0;
    hold_req = 1'b0;
    {acc_n, acc_r, acc_c, acc_rr, acc_cc, acc_rc} = '0;
    acc_ovf = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single point, extremes, axis-aligned lines, diagonals, a repeated point and small mixed blobs.
    add_pixel(0, 0, 1);
    add_pixel(1023, 1023, 1);
    add_pixel(0, 0, 0); add_pixel(1023, 0, 1);
    add_pixel(0, 0, 0); add_pixel(0, 1023, 1);
    add_pixel(0, 0, 0); add_pixel(1023, 1023, 1);
    add_pixel(0, 1023, 0); add_pixel(1023, 0, 1);
    add_pixel(5, 5, 0); add_pixel(5, 5, 0); add_pixel(5, 5, 1);
    add_pixel(0, 1, 0); add_pixel(1, 0, 0); add_pixel(2, 1, 0); add_pixel(1, 2, 1);
    add_pixel(682, 341, 0); add_pixel(341, 682, 0); add_pixel(10, 20, 0);
    add_pixel(20, 50, 1);

    // Random blobs with a burst of calm cycles in the middle.
    for (int k = 0; k < 90; k++) add_blob($urandom_range(1, 8));
    wait (pixel_q.size() == 0);
    calm = 1'b1;
    for (int k = 0; k < 30; k++) add_blob($urandom_range(1, 6));
    wait (pixel_q.size() == 0);
    calm = 1'b0;

    // Receiver hold-off while many short blobs keep arriving.
    @(posedge clk_i);
    hold_req <= 1'b1;
    for (int k = 0; k < 40; k++) add_blob($urandom_range(1, 3));
    wait (pixel_q.size() == 0);

    // Sender pauses until every result has come back.
    pause_req = 1'b1;
    wait (!in_valid && result_q.size() == 0);
    pause_req = 1'b0;

    // More random blobs to finish.
    for (int k = 0; k < 60; k++) add_blob($urandom_range(1, 8));
    wait (pixel_q.size() == 0);
    wait (!in_valid && result_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("covered %0d pixel transfers and %0d blob results, with idle gaps,",
             pixels_sent, results_seen);
    $display("a long receiver hold-off that filled the block, and a sender pause");
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
src/bpa_pkg.sv
src/bpa_front.sv
src/bpa_queue.sv
src/bpa_back.sv
src/blob_principal_axis_angle.sv
tb/sv/blob_principal_axis_angle_test.sv
